// ===== sv/ndd_pkg.sv =====
package ndd_pkg;

    localparam int MAX_POINTS = 64;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = 6;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_SAT  = 2'd1,
        STAT_DUP  = 2'd2,
        STAT_FULL = 2'd3
    } status_t;

    typedef logic signed [DATA_W-1:0] q_t;

    typedef struct packed {
        logic [2*DATA_W-1:0] mag;
        logic                neg;
        logic [2*DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        q_t   quo;
        logic sat;
    } div_res_t;

    // saturating x - y, flag in the top bit
    function automatic logic [DATA_W:0] sub_sat(input q_t x, input q_t y);
        logic signed [DATA_W:0] d;
        begin
            d = {x[DATA_W-1], x} - {y[DATA_W-1], y};
            if (d[DATA_W] != d[DATA_W-1]) begin
                sub_sat = {1'b1, d[DATA_W], {(DATA_W-1){~d[DATA_W]}}};
            end else begin
                sub_sat = {1'b0, d[DATA_W-1:0]};
            end
        end
    endfunction

endpackage

// ===== sv/newton_divided_differences_top.sv =====
// Newton divided-difference coefficient builder, complex Q16.16. Each input word
// carries one node z and its value f (restart in s_axis_tuser begins a new
// sequence); each produces exactly one result word with the Newton coefficient
// of that point, its index and a status (0 ok, 1 saturated, 2 repeated node,
// 3 store full) in m_axis_tuser. The block takes one word at a time: point k
// reads and compares the stored nodes in turn for the repeated-node search,
// then for each of its k diagonal updates reads both memories, uses the shared
// 32x32 multiplier and makes two passes of the shared restoring divider,
// plus accept, store and output steps. The divider is the dominant cost.
// Stored nodes and the diagonal live in two 64-entry memories; no clearing
// pass is needed after reset.
module newton_divided_differences_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // node_real, node_imag, value_real, value_imag
    input  logic [127:0] s_axis_tdata,
    // restart
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // coef_real, coef_imag, coef_index, 2 pad bits
    output logic [71:0]  m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser
);
    import ndd_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_SR_RD   = 10'b0000000010,
        ST_SR_CMP  = 10'b0000000100,
        ST_WRITE   = 10'b0000001000,
        ST_LD_RD   = 10'b0000010000,
        ST_LD_CALC = 10'b0000100000,
        ST_MUL     = 10'b0001000000,
        ST_DIV_RE  = 10'b0010000000,
        ST_DIV_IM  = 10'b0100000000,
        ST_OUT     = 10'b1000000000
    } state_t;

    state_t state_reg;

    // point store: {imag, real}
    logic [2*DATA_W-1:0] node_mem [MAX_POINTS];
    logic [2*DATA_W-1:0] diag_mem [MAX_POINTS];
    logic [2*DATA_W-1:0] node_q;
    logic [2*DATA_W-1:0] diag_q;
    logic                node_we;
    logic                diag_we;
    logic [ADDR_W-1:0]   diag_waddr;
    logic [2*DATA_W-1:0] diag_wdata;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] k_in;
    q_t               zr_reg, zi_reg, fr_reg, fi_reg;
    q_t               up_re_reg, up_im_reg;
    q_t               a_reg, b_reg, c_reg, d_reg;
    logic             sat_reg;

    logic [2:0]               mul_cnt_reg;
    q_t                       mul_x, mul_y;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [2*DATA_W:0]   acc_re_reg, acc_im_reg;
    logic [2*DATA_W-1:0]        den_reg;

    logic     div_go_reg;
    logic     div_done;
    div_req_t div_req;
    div_res_t div_res;
    logic signed [2*DATA_W:0] div_num;
    q_t       qre_reg;

    logic [DATA_W:0] sa, sb, sc, sd;

    q_t          pend_re_reg, pend_im_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    status_t     pend_stat_reg;

    logic             m_valid_reg;
    q_t               m_re_reg, m_im_reg;
    logic [IDX_W-1:0] m_idx_reg;
    status_t          m_stat_reg;

    logic s_acc;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign k_in          = s_axis_tuser[0] ? '0 : count_reg;

    // storage
    assign node_we    = (state_reg == ST_WRITE);
    assign diag_we    = (state_reg == ST_WRITE) || (state_reg == ST_DIV_IM && div_done);
    assign diag_waddr = (state_reg == ST_WRITE) ? k_reg[ADDR_W-1:0] : j_reg[ADDR_W-1:0];
    assign diag_wdata = (state_reg == ST_WRITE) ? {fi_reg, fr_reg} : {div_res.quo, qre_reg};

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[k_reg[ADDR_W-1:0]] <= {zi_reg, zr_reg};
        end
        node_q <= node_mem[j_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (diag_we) begin
            diag_mem[diag_waddr] <= diag_wdata;
        end
        diag_q <= diag_mem[j_reg[ADDR_W-1:0]];
    end

    // operand differences for one diagonal step
    assign sa = sub_sat(up_re_reg, diag_q[DATA_W-1:0]);
    assign sb = sub_sat(up_im_reg, diag_q[2*DATA_W-1:DATA_W]);
    assign sc = sub_sat(zr_reg, node_q[DATA_W-1:0]);
    assign sd = sub_sat(zi_reg, node_q[2*DATA_W-1:DATA_W]);

    // shared multiplier operand order: ac, bd, bc, ad, cc, dd
    always_comb begin
        unique case (mul_cnt_reg)
            3'd0:    begin mul_x = a_reg; mul_y = c_reg; end
            3'd1:    begin mul_x = b_reg; mul_y = d_reg; end
            3'd2:    begin mul_x = b_reg; mul_y = c_reg; end
            3'd3:    begin mul_x = a_reg; mul_y = d_reg; end
            3'd4:    begin mul_x = c_reg; mul_y = c_reg; end
            default: begin mul_x = d_reg; mul_y = d_reg; end
        endcase
    end

    assign div_num     = (state_reg == ST_DIV_IM) ? acc_im_reg : acc_re_reg;
    assign div_req.neg = div_num[2*DATA_W];
    assign div_req.mag = div_num[2*DATA_W] ? (2*DATA_W)'(-div_num)
                                           : div_num[2*DATA_W-1:0];
    assign div_req.den = den_reg;

    ndd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go_reg),
        .req     (div_req),
        .done    (div_done),
        .res     (div_res)
    );

    always_ff @(posedge aclk) begin
        prod_reg <= mul_x * mul_y;
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            div_go_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            div_go_reg <= 1'b0;
            if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        zr_reg    <= s_axis_tdata[31:0];
                        zi_reg    <= s_axis_tdata[63:32];
                        fr_reg    <= s_axis_tdata[95:64];
                        fi_reg    <= s_axis_tdata[127:96];
                        k_reg     <= k_in;
                        j_reg     <= '0;
                        sat_reg   <= 1'b0;
                        count_reg <= k_in;
                        if (k_in >= CNT_W'(MAX_POINTS)) begin
                            pend_re_reg   <= '0;
                            pend_im_reg   <= '0;
                            pend_idx_reg  <= '0;
                            pend_stat_reg <= STAT_FULL;
                            state_reg     <= ST_OUT;
                        end else if (k_in == '0) begin
                            state_reg <= ST_WRITE;
                        end else begin
                            state_reg <= ST_SR_RD;
                        end
                    end
                end
                ST_SR_RD: state_reg <= ST_SR_CMP;
                ST_SR_CMP: begin
                    if (node_q == {zi_reg, zr_reg}) begin
                        pend_re_reg   <= '0;
                        pend_im_reg   <= '0;
                        pend_idx_reg  <= k_reg[IDX_W-1:0];
                        pend_stat_reg <= STAT_DUP;
                        state_reg     <= ST_OUT;
                    end else if (j_reg + CNT_W'(1) == k_reg) begin
                        state_reg <= ST_WRITE;
                    end else begin
                        j_reg     <= j_reg + CNT_W'(1);
                        state_reg <= ST_SR_RD;
                    end
                end
                ST_WRITE: begin
                    up_re_reg <= fr_reg;
                    up_im_reg <= fi_reg;
                    if (k_reg == '0) begin
                        pend_re_reg   <= fr_reg;
                        pend_im_reg   <= fi_reg;
                        pend_idx_reg  <= '0;
                        pend_stat_reg <= STAT_OK;
                        count_reg     <= CNT_W'(1);
                        state_reg     <= ST_OUT;
                    end else begin
                        j_reg     <= k_reg - CNT_W'(1);
                        state_reg <= ST_LD_RD;
                    end
                end
                ST_LD_RD: state_reg <= ST_LD_CALC;
                ST_LD_CALC: begin
                    a_reg       <= sa[DATA_W-1:0];
                    b_reg       <= sb[DATA_W-1:0];
                    c_reg       <= sc[DATA_W-1:0];
                    d_reg       <= sd[DATA_W-1:0];
                    sat_reg     <= sat_reg | sa[DATA_W] | sb[DATA_W] | sc[DATA_W] | sd[DATA_W];
                    mul_cnt_reg <= '0;
                    state_reg   <= ST_MUL;
                end
                ST_MUL: begin
                    mul_cnt_reg <= mul_cnt_reg + 3'd1;
                    unique case (mul_cnt_reg)
                        3'd0: ;
                        3'd1: acc_re_reg <= (2*DATA_W+1)'(prod_reg);
                        3'd2: acc_re_reg <= acc_re_reg + (2*DATA_W+1)'(prod_reg);
                        3'd3: acc_im_reg <= (2*DATA_W+1)'(prod_reg);
                        3'd4: acc_im_reg <= acc_im_reg - (2*DATA_W+1)'(prod_reg);
                        3'd5: den_reg    <= prod_reg;
                        default: begin
                            den_reg    <= den_reg + prod_reg;
                            div_go_reg <= 1'b1;
                            state_reg  <= ST_DIV_RE;
                        end
                    endcase
                end
                ST_DIV_RE: begin
                    if (div_done) begin
                        qre_reg    <= div_res.quo;
                        sat_reg    <= sat_reg | div_res.sat;
                        div_go_reg <= 1'b1;
                        state_reg  <= ST_DIV_IM;
                    end
                end
                ST_DIV_IM: begin
                    if (div_done) begin
                        up_re_reg <= qre_reg;
                        up_im_reg <= div_res.quo;
                        if (j_reg == '0) begin
                            pend_re_reg   <= qre_reg;
                            pend_im_reg   <= div_res.quo;
                            pend_idx_reg  <= k_reg[IDX_W-1:0];
                            pend_stat_reg <= (sat_reg | div_res.sat) ? STAT_SAT : STAT_OK;
                            count_reg     <= k_reg + CNT_W'(1);
                            state_reg     <= ST_OUT;
                        end else begin
                            sat_reg   <= sat_reg | div_res.sat;
                            j_reg     <= j_reg - CNT_W'(1);
                            state_reg <= ST_LD_RD;
                        end
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg <= 1'b1;
                        m_re_reg    <= pend_re_reg;
                        m_im_reg    <= pend_im_reg;
                        m_idx_reg   <= pend_idx_reg;
                        m_stat_reg  <= pend_stat_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_idx_reg, m_im_reg, m_re_reg};
    assign m_axis_tuser  = m_stat_reg;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_axis_tready)
        else $error("input taken while a word is in progress");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store");

    a_load_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result loaded outside the output step");

    a_full_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_stat_reg == STAT_FULL) |-> (m_idx_reg == '0))
        else $error("store-full result with nonzero index");
`endif

endmodule

// ===== sv/ndd_div.sv =====
module ndd_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  ndd_pkg::div_req_t req,
    output logic              done,
    output ndd_pkg::div_res_t res
);
    import ndd_pkg::*;

    localparam int NW = 2*DATA_W + FRAC_BITS;

    typedef enum logic [2:0] {
        DV_IDLE = 3'b001,
        DV_RUN  = 3'b010,
        DV_FIN  = 3'b100
    } dv_state_t;

    dv_state_t           state_reg;
    logic [NW-1:0]       num;
    logic [2*DATA_W-1:0] num_hi;
    logic [2*DATA_W-1:0] r_reg;
    logic [2*DATA_W-1:0] den_reg;
    logic [DATA_W-1:0]   lo_reg;
    logic [DATA_W-1:0]   q_reg;
    logic [5:0]          cnt_reg;
    logic                neg_reg;
    logic                zero_reg;
    logic                ovf_reg;
    logic                done_reg;
    div_res_t            res_reg;
    logic [2*DATA_W:0]   trial;
    logic                big;

    assign num    = NW'(req.mag) << FRAC_BITS;
    assign num_hi = (2*DATA_W)'(num >> DATA_W);
    assign trial  = {r_reg, lo_reg[DATA_W-1]};
    // magnitude beyond the signed limit
    assign big    = neg_reg ? (q_reg > {1'b1, {(DATA_W-1){1'b0}}}) : q_reg[DATA_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                DV_IDLE: begin
                    if (start) begin
                        neg_reg  <= req.neg;
                        den_reg  <= req.den;
                        zero_reg <= (req.den == '0);
                        ovf_reg  <= (num_hi >= req.den);
                        r_reg    <= num_hi;
                        lo_reg   <= num[DATA_W-1:0];
                        q_reg    <= '0;
                        cnt_reg  <= '0;
                        if (req.den == '0 || num_hi >= req.den) begin
                            state_reg <= DV_FIN;
                        end else begin
                            state_reg <= DV_RUN;
                        end
                    end
                end
                DV_RUN: begin
                    if (trial >= {1'b0, den_reg}) begin
                        r_reg <= (2*DATA_W)'(trial - {1'b0, den_reg});
                        q_reg <= {q_reg[DATA_W-2:0], 1'b1};
                    end else begin
                        r_reg <= trial[2*DATA_W-1:0];
                        q_reg <= {q_reg[DATA_W-2:0], 1'b0};
                    end
                    lo_reg  <= lo_reg << 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(DATA_W - 1)) begin
                        state_reg <= DV_FIN;
                    end
                end
                DV_FIN: begin
                    if (zero_reg) begin
                        res_reg <= '{quo: '0, sat: 1'b1};
                    end else if (ovf_reg || big) begin
                        res_reg.sat <= 1'b1;
                        res_reg.quo <= neg_reg ? {1'b1, {(DATA_W-1){1'b0}}}
                                               : {1'b0, {(DATA_W-1){1'b1}}};
                    end else begin
                        res_reg.sat <= 1'b0;
                        res_reg.quo <= neg_reg ? -q_reg : q_reg;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= DV_IDLE;
                end
                default: state_reg <= DV_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
